// ===== rtl/core/tbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpf_pkg
// shared constants, codes and widths for the text background pixel fetch
// ----------------------------------------------------------------------------
package tbpf_pkg;

    // video memory geometry
    localparam int VRAM_WORDS   = 32768;
    localparam int VRAM_AW      = $clog2(VRAM_WORDS);
    localparam int VRAM_DW      = 16;

    // visible width in pixels
    localparam int SCREEN_WIDTH = 240;

    // stream payload widths
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 8;

    // configuration port widths
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 9;

    // command codes carried in s_tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAP_BASE    = 3'd0,
        CFG_TILE_BASE   = 3'd1,
        CFG_SCREEN_SIZE = 3'd2,
        CFG_SCROLL_X    = 3'd3,
        CFG_SCROLL_Y    = 3'd4
    } cfg_index_t;

endpackage

// ===== rtl/core/tbpf_ram.sv =====
// ----------------------------------------------------------------------------
// tbpf_ram
// generic ram, one write port and two registered read ports (read-first)
// ----------------------------------------------------------------------------
module tbpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/core/text_background_pixel_fetch.sv =====
// ----------------------------------------------------------------------------
// text_background_pixel_fetch
// 4bpp tiled text background layer: video memory writes and per-pixel fetch
// ----------------------------------------------------------------------------
// path: an accepted input beat moves through the stage registers, then the output register, to its result beat
// throughput: one beat per cycle unless the output stalls; a write directly
//   behind a render is held back, since its write would land between the render's map and tile reads
// reset: rst_n clears valid bits and config registers (all zero); video memory
//   holds no reset value and must be written before it is read
// ----------------------------------------------------------------------------
module text_background_pixel_fetch (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vram_address[14:0] write_data[30:15] line[38:31] column[46:39] zero[47]
    input  logic [tbpf_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // color_index[3:0] palette_bank[7:4]
    output logic [tbpf_pkg::M_TDATA_W-1:0]     m_tdata,
    // pixel_valid[0]
    output logic                               m_tuser,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tbpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tbpf_pkg::*;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [4:0] map_base_reg;
    logic [1:0] tile_base_reg;
    logic [1:0] screen_size_reg;
    logic [8:0] scroll_x_reg;
    logic [8:0] scroll_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_base_reg    <= '0;
            tile_base_reg   <= '0;
            screen_size_reg <= '0;
            scroll_x_reg    <= '0;
            scroll_y_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAP_BASE:    map_base_reg    <= cfg_data[4:0];
                CFG_TILE_BASE:   tile_base_reg   <= cfg_data[1:0];
                CFG_SCREEN_SIZE: screen_size_reg <= cfg_data[1:0];
                CFG_SCROLL_X:    scroll_x_reg    <= cfg_data[8:0];
                CFG_SCROLL_Y:    scroll_y_reg    <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline control
    // the whole pipe advances together; it holds only while the output beat
    // waits and the sink is not ready
    // ------------------------------------------------------------------------
    logic advance;
    logic wr_hazard;
    logic in_take;

    logic out_valid_reg;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic s5_valid_reg, s5_valid_next;
    logic out_valid_next;

    logic s1_cmd_reg;
    logic s2_cmd_reg;
    logic s3_cmd_reg;

    assign advance = !out_valid_reg || m_tready;

    // a write right behind a render would land before that render's tile read
    assign wr_hazard = (s_tuser == CMD_WRITE) && s1_valid_reg && (s1_cmd_reg == CMD_RENDER);

    assign s_tready = advance && !wr_hazard;
    assign in_take  = s_tvalid && s_tready;

    assign s1_valid_next  = in_take;
    assign s2_valid_next  = s1_valid_reg;
    assign s3_valid_next  = s2_valid_reg;
    assign s4_valid_next  = s3_valid_reg;
    assign s5_valid_next  = s4_valid_reg;
    assign out_valid_next = s5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            s5_valid_reg  <= s5_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: input beat registered
    // ------------------------------------------------------------------------
    logic [14:0] s1_addr_reg;
    logic [15:0] s1_data_reg;
    logic [7:0]  s1_line_reg;
    logic [7:0]  s1_col_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cmd_reg  <= s_tuser;
            s1_addr_reg <= s_tdata[14:0];
            s1_data_reg <= s_tdata[30:15];
            s1_line_reg <= s_tdata[38:31];
            s1_col_reg  <= s_tdata[46:39];
        end
    end

    // ------------------------------------------------------------------------
    // stage 1 -> 2: scroll, block select, map entry address
    // ------------------------------------------------------------------------
    logic [8:0]         bx;
    logic [8:0]         by;
    logic [1:0]         blk;
    logic [16:0]        map_addr_wide;
    logic               s1_vis;

    logic               s2_vis_reg,      s2_vis_next;
    logic [VRAM_AW-1:0] s2_map_addr_reg, s2_map_addr_next;
    logic [2:0]         s2_px_reg,       s2_px_next;
    logic [2:0]         s2_py_reg,       s2_py_next;
    logic [VRAM_AW-1:0] s2_wr_addr_reg,  s2_wr_addr_next;
    logic [15:0]        s2_wr_data_reg;

    always_comb
    begin
        // background position wraps at 512 by width
        bx = scroll_x_reg + {1'b0, s1_col_reg};
        by = scroll_y_reg + {1'b0, s1_line_reg};

        // which 32x32 map block, by screen size
        case (screen_size_reg)
            2'd1:    blk = {1'b0, bx[8]};
            2'd2:    blk = {1'b0, by[8]};
            2'd3:    blk = {by[8], bx[8]};
            default: blk = 2'd0;
        endcase

        // halfword address: 1 KiB halfwords per block, 32 entries per row
        map_addr_wide = ((17'(map_base_reg) + 17'(blk)) << 10)
                      + 17'({by[7:3], bx[7:3]});

        // off-screen columns answer with zeros
        s1_vis = (s1_cmd_reg == CMD_RENDER)
              && ({2'b00, s1_col_reg} < 10'(SCREEN_WIDTH));

        s2_vis_next      = s1_vis;
        s2_map_addr_next = map_addr_wide[VRAM_AW-1:0];
        s2_px_next       = bx[2:0];
        s2_py_next       = by[2:0];
        s2_wr_addr_next  = s1_addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_cmd_reg      <= s1_cmd_reg;
            s2_vis_reg      <= s2_vis_next;
            s2_map_addr_reg <= s2_map_addr_next;
            s2_px_reg       <= s2_px_next;
            s2_py_reg       <= s2_py_next;
            s2_wr_addr_reg  <= s2_wr_addr_next;
            s2_wr_data_reg  <= s1_data_reg;
        end
    end

    // ------------------------------------------------------------------------
    // video memory: write and map read in stage 2, tile read in stage 4
    // ------------------------------------------------------------------------
    logic               ram_we;
    logic [VRAM_AW-1:0] s4_tile_addr_reg;
    logic [VRAM_DW-1:0] map_entry;
    logic [VRAM_DW-1:0] tile_half;

    assign ram_we = advance && s2_valid_reg && (s2_cmd_reg == CMD_WRITE);

    tbpf_ram #(
        .WIDTH (VRAM_DW),
        .DEPTH (VRAM_WORDS)
    ) u_vram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s2_wr_addr_reg),
        .wdata   (s2_wr_data_reg),
        .re      (advance),
        .raddr_a (s2_map_addr_reg),
        .rdata_a (map_entry),
        .raddr_b (s4_tile_addr_reg),
        .rdata_b (tile_half)
    );

    // ------------------------------------------------------------------------
    // stage 3: map entry arrives with its control
    // ------------------------------------------------------------------------
    logic       s3_vis_reg;
    logic [2:0] s3_px_reg;
    logic [2:0] s3_py_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            s3_vis_reg <= s2_vis_reg;
            s3_px_reg  <= s2_px_reg;
            s3_py_reg  <= s2_py_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3 -> 4: flips and tile address
    // ------------------------------------------------------------------------
    logic [2:0]         px_f;
    logic [2:0]         py_f;
    logic [16:0]        tile_addr_wide;
    logic [VRAM_AW-1:0] s4_tile_addr_next;

    logic               s4_vis_reg;
    logic               s4_byte_sel_reg;
    logic               s4_nib_sel_reg;
    logic [3:0]         s4_bank_reg;

    always_comb
    begin
        // 7 - p is the complement of a 3-bit coordinate
        px_f = map_entry[10] ? ~s3_px_reg : s3_px_reg;
        py_f = map_entry[11] ? ~s3_py_reg : s3_py_reg;

        // 16 halfwords per tile, 2 per row, then half of the byte pair index
        tile_addr_wide = (17'(tile_base_reg) << 13)
                       + (17'(map_entry[9:0]) << 4)
                       + 17'({py_f, px_f[2]});
        s4_tile_addr_next = tile_addr_wide[VRAM_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_vis_reg       <= s3_vis_reg;
            s4_tile_addr_reg <= s4_tile_addr_next;
            s4_byte_sel_reg  <= px_f[1];
            s4_nib_sel_reg   <= px_f[0];
            s4_bank_reg      <= map_entry[15:12];
        end
    end

    // ------------------------------------------------------------------------
    // stage 5: tile halfword arrives
    // ------------------------------------------------------------------------
    logic       s5_vis_reg;
    logic       s5_byte_sel_reg;
    logic       s5_nib_sel_reg;
    logic [3:0] s5_bank_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_vis_reg      <= s4_vis_reg;
            s5_byte_sel_reg <= s4_byte_sel_reg;
            s5_nib_sel_reg  <= s4_nib_sel_reg;
            s5_bank_reg     <= s4_bank_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 5 -> output: byte and nibble select, zeros for writes/off-screen
    // ------------------------------------------------------------------------
    logic [7:0] tile_byte;
    logic [3:0] nibble;

    logic       out_pix_reg,   out_pix_next;
    logic [3:0] out_color_reg, out_color_next;
    logic [3:0] out_bank_reg,  out_bank_next;

    always_comb
    begin
        // little-endian: even byte is the low byte
        tile_byte = s5_byte_sel_reg ? tile_half[15:8] : tile_half[7:0];
        nibble    = s5_nib_sel_reg ? tile_byte[7:4] : tile_byte[3:0];

        out_pix_next   = s5_vis_reg;
        out_color_next = s5_vis_reg ? nibble : 4'd0;
        out_bank_next  = s5_vis_reg ? s5_bank_reg : 4'd0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pix_reg   <= out_pix_next;
            out_color_reg <= out_color_next;
            out_bank_reg  <= out_bank_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pix_reg;
    assign m_tdata  = {out_bank_reg, out_color_reg};

`ifndef NO_ASSERTIONS
    // the write port never lands between a render's map read and tile read
    a_no_write_over_render : assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_cmd_reg == CMD_WRITE))
        |-> !(s3_valid_reg && (s3_cmd_reg == CMD_RENDER)))
        else $error("write in stage 2 behind a render in stage 3");

    // acknowledgements and off-screen pixels carry zero payload
    a_ack_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("non-pixel result beat with nonzero payload");

    // a held output beat stalls the input side
    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the pipe is stalled");
`endif

endmodule

// ===== tb/sv/text_background_pixel_fetch_tb.sv =====
// ----------------------------------------------------------------------------
// text_background_pixel_fetch_tb
// self-checking bench for the 4bpp text background pixel fetch: drives video
// memory writes and pixel renders under several register settings and idle
// patterns, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module text_background_pixel_fetch_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tbpf_pkg::*;

    // cycles with no beat on any channel before the run is declared hung
    localparam int QUIET_LIMIT   = 4000;
    // settle time once the last expected pixel has arrived
    localparam int SETTLE_CYCLES = 8;
    // receiver hold-off used to back the pipeline up into the input
    localparam int HOLD_OFF      = 400;

    // one result beat as the block reports it
    typedef struct packed {
        logic       pixel_valid;
        logic [3:0] color_index;
        logic [3:0] palette_bank;
    } pixel_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // shadow of the block's registers and video memory
    logic [4:0]  map_base_q;
    logic [1:0]  tile_base_q;
    logic [1:0]  screen_size_q;
    logic [8:0]  scroll_x_q;
    logic [8:0]  scroll_y_q;
    logic [15:0] vram_mirror  [VRAM_WORDS];
    bit          vram_written [VRAM_WORDS];

    // pixels still owed by the block, oldest first
    pixel_t      pixel_queue [$];

    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int          hold_cycles   = 0;
    int unsigned beats_sent    = 0;
    int          error_count   = 0;
    int          quiet_cycles  = 0;

    text_background_pixel_fetch u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // pixel predictor
    // ------------------------------------------------------------------------

    // halfword index of the map entry covering a screen position
    function automatic logic [14:0] map_half_addr(input logic [7:0] ln, input logic [7:0] col);
        logic [8:0]  bx;
        logic [8:0]  by;
        logic [1:0]  blk;
        logic [16:0] byte_addr;
        // background position wraps at 512 in both directions
        bx = col + scroll_x_q;
        by = ln + scroll_y_q;
        // map block select: the ninth coordinate bit only counts in wide/tall modes
        case (screen_size_q)
            2'd1:    blk = {1'b0, bx[8]};
            2'd2:    blk = {1'b0, by[8]};
            2'd3:    blk = {by[8], bx[8]};
            default: blk = 2'd0;
        endcase
        byte_addr = 17'(map_base_q * 2048 + blk * 2048 + 2 * (32 * by[7:3] + bx[7:3]));
        // halfword index, wrapped to the memory size
        return byte_addr[15:1];
    endfunction

    // byte address of the tile byte for a position, after the flips
    function automatic logic [16:0] tile_byte_addr(input logic [15:0] entry,
                                                   input logic [7:0] ln, input logic [7:0] col);
        logic [8:0] bx;
        logic [8:0] by;
        logic [2:0] px;
        logic [2:0] py;
        bx = col + scroll_x_q;
        by = ln + scroll_y_q;
        // 7 - p is the bitwise inverse on three bits
        px = entry[10] ? ~bx[2:0] : bx[2:0];
        py = entry[11] ? ~by[2:0] : by[2:0];
        return 17'(tile_base_q * 16384 + 32 * entry[9:0] + 4 * py + px[2:1]);
    endfunction

    function automatic pixel_t render_pixel(input logic [7:0] ln, input logic [7:0] col);
        pixel_t      pix;
        logic [15:0] entry;
        logic [15:0] half;
        logic [16:0] taddr;
        logic [7:0]  tbyte;
        logic [8:0]  bx;
        pix = '0;
        // off-screen column answers all zero and reads nothing
        if (col >= SCREEN_WIDTH)
            return pix;
        entry = vram_mirror[map_half_addr(ln, col)];
        taddr = tile_byte_addr(entry, ln, col);
        half  = vram_mirror[taddr[15:1]];
        // little-endian: even byte address is the low byte
        tbyte = taddr[0] ? half[15:8] : half[7:0];
        bx    = col + scroll_x_q;
        pix.pixel_valid  = 1'b1;
        // odd pixel after h-flip takes the high nibble
        pix.color_index  = (bx[0] ^ entry[10]) ? tbyte[7:4] : tbyte[3:0];
        pix.palette_bank = entry[15:12];
        return pix;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------------

    // offer one input beat; the prediction is made once it is accepted, so the
    // shadow memory always reflects every write ahead of it in the stream
    task automatic send_beat(input logic cmd, input logic [14:0] addr, input logic [15:0] data,
                             input logic [7:0] ln, input logic [7:0] col);
        pixel_t want;
        // random gap; valid stays high between back-to-back beats
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, col, ln, data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == CMD_WRITE)
        begin
            vram_mirror[addr]  = data;
            vram_written[addr] = 1'b1;
            // write acknowledge carries all-zero fields
            want = '0;
        end
        else
            want = render_pixel(ln, col);
        pixel_queue.push_back(want);
        beats_sent++;
    endtask

    // render one pixel, first writing whatever map entry or tile halfword it
    // would read that was never stored; put_entry forces a chosen map entry
    task automatic render_item(input logic [7:0] ln, input logic [7:0] col,
                               input bit put_entry, input logic [15:0] entry);
        logic [14:0] maddr;
        logic [16:0] taddr;
        if (col < SCREEN_WIDTH)
        begin
            maddr = map_half_addr(ln, col);
            if (put_entry || !vram_written[maddr])
                send_beat(CMD_WRITE, maddr, put_entry ? entry : 16'($urandom),
                          8'($urandom), 8'($urandom));
            taddr = tile_byte_addr(vram_mirror[maddr], ln, col);
            if (!vram_written[taddr[15:1]])
                send_beat(CMD_WRITE, taddr[15:1], 16'($urandom), 8'($urandom), 8'($urandom));
        end
        send_beat(CMD_RENDER, 15'($urandom), 16'($urandom), ln, col);
    endtask

    // stop offering and wait until every owed pixel has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register beat; valid is left high for a following write
    task automatic write_reg(input cfg_index_t idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MAP_BASE:    map_base_q    = val[4:0];
            CFG_TILE_BASE:   tile_base_q   = val[1:0];
            CFG_SCREEN_SIZE: screen_size_q = val[1:0];
            CFG_SCROLL_X:    scroll_x_q    = val;
            CFG_SCROLL_Y:    scroll_y_q    = val;
            default: ;
        endcase
    endtask

    // registers only change with the block idle
    task automatic set_config(input logic [4:0] mb, input logic [1:0] tb, input logic [1:0] ss,
                              input logic [8:0] sx, input logic [8:0] sy);
        drain_results();
        write_reg(CFG_MAP_BASE, {4'd0, mb});
        write_reg(CFG_TILE_BASE, {7'd0, tb});
        write_reg(CFG_SCREEN_SIZE, {7'd0, ss});
        write_reg(CFG_SCROLL_X, sx);
        write_reg(CFG_SCROLL_Y, sy);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // write acknowledge at the address and data extremes
    task automatic test_write_ack();
        send_beat(CMD_WRITE, 15'h0000, 16'h0000, 8'h00, 8'h00);
        send_beat(CMD_WRITE, 15'h7fff, 16'hffff, 8'hff, 8'hff);
    endtask

    // flip combinations, palette banks, odd/even pixels, lines past the screen
    task automatic test_flips_and_banks();
        set_config(5'd0, 2'd0, 2'd0, 9'd0, 9'd0);
        render_item(8'd3, 8'd5, 1'b1, 16'h5405);      // h-flip, bank 5
        render_item(8'd6, 8'd2, 1'b1, 16'ha80a);      // v-flip, bank 10
        render_item(8'd159, 8'd1, 1'b1, 16'h0c21);    // both flips, odd pixel
        render_item(8'd255, 8'd239, 1'b1, 16'hffff);  // max tile, line past the screen
    endtask

    // columns at and beyond the screen width answer all zero
    task automatic test_offscreen();
        render_item(8'd0, 8'(SCREEN_WIDTH), 1'b0, 16'h0000);
        render_item(8'd159, 8'd255, 1'b0, 16'h0000);
    endtask

    // every register at its maximum; scroll pushes the position across 512
    task automatic test_config_extremes();
        set_config(5'd31, 2'd3, 2'd3, 9'd511, 9'd511);
        render_item(8'd0, 8'd0, 1'b0, 16'h0000);
        render_item(8'd200, 8'd100, 1'b0, 16'h0000);
    endtask

    // smaller maps wrap at 256 on their short side(s)
    task automatic test_small_maps();
        set_config(5'd3, 2'd1, 2'd0, 9'd300, 9'd400);
        render_item(8'd20, 8'd30, 1'b0, 16'h0000);
        set_config(5'd7, 2'd2, 2'd1, 9'd300, 9'd300);
        render_item(8'd20, 8'd30, 1'b0, 16'h0000);
        set_config(5'd12, 2'd0, 2'd2, 9'd300, 9'd300);
        render_item(8'd20, 8'd30, 1'b0, 16'h0000);
    endtask

    // receiver holds off while the sender keeps offering along a scanline
    task automatic test_backpressure();
        int col;
        set_config(5'd0, 2'd0, 2'd3, 9'd17, 9'd33);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_cycles    = HOLD_OFF;
        for (col = 0; col < 60; col++)
            render_item(8'd40, 8'(col), 1'b0, 16'h0000);
    endtask

    // random register setting, then scanline-ordered renders with random content,
    // some scattered and off-screen renders, forced entries and stray writes
    task automatic test_random_traffic(input int unsigned n);
        int unsigned start;
        int          pick;
        logic [7:0]  scan_ln;
        logic [7:0]  scan_col;
        start    = beats_sent;
        scan_ln  = 8'($urandom);
        scan_col = 8'($urandom_range(SCREEN_WIDTH - 1));
        set_config(5'($urandom), 2'($urandom), 2'($urandom), 9'($urandom), 9'($urandom));
        while (beats_sent - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // next pixel along the scanline, reusing map entries and tiles
                render_item(scan_ln, scan_col, 1'b0, 16'h0000);
                if (scan_col == SCREEN_WIDTH - 1)
                begin
                    scan_col = 8'd0;
                    scan_ln  = scan_ln + 8'd1;
                end
                else
                    scan_col = scan_col + 8'd1;
            end
            else if (pick < 65)
                render_item(8'($urandom), 8'($urandom_range(SCREEN_WIDTH - 1)),
                            1'b0, 16'h0000);
            else if (pick < 77)
                render_item(8'($urandom), 8'($urandom_range(SCREEN_WIDTH - 1)),
                            1'b1, 16'($urandom));
            else if (pick < 85)
                render_item(8'($urandom), 8'($urandom_range(255, SCREEN_WIDTH)),
                            1'b0, 16'h0000);
            else
                // stray write anywhere, possibly over a live map entry or tile
                send_beat(CMD_WRITE, 15'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin : result_sink
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each result beat against the oldest owed pixel
    always @(posedge clk)
    begin : check_beats
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pixel_valid  = m_tuser;
            got.color_index  = m_tdata[3:0];
            got.palette_bank = m_tdata[7:4];
            if (pixel_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat: valid=%0d color=%0d bank=%0d",
                             got.pixel_valid, got.color_index, got.palette_bank);
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (got.pixel_valid !== want.pixel_valid
                    || got.color_index !== want.color_index
                    || got.palette_bank !== want.palette_bank)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("pixel mismatch at %0t", $realtime);
                        $display("  expected valid=%0d color=%0d bank=%0d",
                                 want.pixel_valid, want.color_index, want.palette_bank);
                        $display("  got      valid=%0d color=%0d bank=%0d",
                                 got.pixel_valid, got.color_index, got.palette_bank);
                    end
                end
            end
        end
    end

    // watchdog: too long without a beat on any channel means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // all inputs known from time zero
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_WRITE;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAP_BASE;
        cfg_data  <= '0;
        // registers come out of reset at zero
        map_base_q    = '0;
        tile_base_q   = '0;
        screen_size_q = '0;
        scroll_x_q    = '0;
        scroll_y_q    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        test_write_ack();
        test_flips_and_banks();
        test_offscreen();
        test_config_extremes();
        test_small_maps();
        test_backpressure();

        // random part under each idle pattern, two register settings apiece
        src_idle_pct = 0;  sink_stall_pct = 0;
        test_random_traffic(215);
        test_random_traffic(215);
        src_idle_pct = 80; sink_stall_pct = 0;
        test_random_traffic(215);
        test_random_traffic(215);
        src_idle_pct = 0;  sink_stall_pct = 80;
        test_random_traffic(215);
        test_random_traffic(215);
        src_idle_pct = 19; sink_stall_pct = 19;
        test_random_traffic(215);
        test_random_traffic(215);

        // every owed pixel back, then a quiet spell to catch stray beats
        drain_results();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
